// File: sv/sliding_window_reassembly_core_assert.svh
// assertion macros for the reassembly core checker
// depends on nothing; expects clk_i and rst_ni in the using scope
`ifndef SLIDING_WINDOW_REASSEMBLY_CORE_ASSERT_SVH
`define SLIDING_WINDOW_REASSEMBLY_CORE_ASSERT_SVH

// same-cycle implication
`define SWR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("reassembly core check failed");

// next-cycle implication
`define SWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("reassembly core check failed");

`endif

// File: sv/swr_pkg.sv
// shared types and constants of the reassembly core
// no dependencies
`default_nettype none
package swr_pkg;

  localparam int unsigned WINDOW_SLOTS = 32;
  localparam int unsigned SLOT_IW      = $clog2(WINDOW_SLOTS);

  localparam logic [15:0] SEG_SIZE_RST = 16'd1000;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DUP      = 2'd1,
    ST_OUTSIDE  = 2'd2,
    ST_INIT     = 2'd3
  } status_e;

  typedef enum logic {
    REG_TOTAL_LEN = 1'b0,
    REG_SEG_SIZE  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_RETIRE = 1'b1
  } kind_e;

  typedef enum logic {
    ACT_BEGIN   = 1'b0,
    ACT_ARRIVAL = 1'b1
  } action_e;

  typedef struct packed {
    logic take;
    logic fill;
    logic scan;
    logic stat;
    logic ret;
  } cmd_t;

  typedef struct packed {
    logic is_begin;
    logic cnt_end;
    logic hit;
    logic out_free;
    logic stat_more;
    logic ret_more;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/swr_ctrl.sv
// sequencer of the reassembly core: fill, scan, status and retire phases
// depends on swr_pkg
`default_nettype none
module swr_ctrl import swr_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_SCAN, S_STAT, S_RET
  } state_e;

  state_e state_q;
  logic   rdy_q;

  assign in_ready_o = rdy_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.take = in_valid_i && rdy_q;
      S_FILL: cmd_o.fill = 1'b1;
      S_SCAN: cmd_o.scan = 1'b1;
      S_STAT: cmd_o.stat = sts_i.out_free;
      S_RET:  cmd_o.ret  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && rdy_q) begin
            rdy_q   <= 1'b0;
            state_q <= sts_i.is_begin ? S_FILL : S_SCAN;
          end
        end
        S_FILL: begin
          if (sts_i.cnt_end) state_q <= S_STAT;
        end
        S_SCAN: begin
          if (sts_i.hit || sts_i.cnt_end) state_q <= S_STAT;
        end
        S_STAT: begin
          if (sts_i.out_free) begin
            if (sts_i.stat_more) begin
              state_q <= S_RET;
            end else begin
              state_q <= S_IDLE;
              rdy_q   <= 1'b1;
            end
          end
        end
        S_RET: begin
          if (sts_i.out_free && !sts_i.ret_more) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/swr_dp.sv
// datapath of the reassembly core: slot ring, config, counters, result register
// depends on swr_pkg
`default_nettype none
module swr_dp import swr_pkg::*; (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        cfg_valid_i,
  input  wire  logic        cfg_index_i,
  input  wire  logic [31:0] cfg_data_i,
  input  wire  logic        in_action_i,
  input  wire  logic [31:0] in_start_i,
  input  wire  logic [15:0] in_length_i,
  output logic              out_valid_o,
  input  wire  logic        out_ready_i,
  output logic              out_kind_o,
  output logic              out_last_o,
  output logic [87:0]       out_data_o,
  input  wire  cmd_t        cmd_i,
  output sts_t              sts_o
);

  localparam logic [SLOT_IW-1:0] LAST_IDX = SLOT_IW'(WINDOW_SLOTS - 1);
  localparam logic [33:0]        OFF_CAP  = 34'h1_0000_0000;

  logic [31:0] off_q  [WINDOW_SLOTS];
  logic [15:0] size_q [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] rdy_bits_q;

  logic [31:0] total_q;
  logic [15:0] seg_q;
  logic [SLOT_IW-1:0] head_q, ptr_q, cnt_q, fnd_q;
  logic        fnd_v_q;
  logic [32:0] noff_q;
  logic [31:0] left_q;
  logic        act_q;
  logic [31:0] start_q;
  logic [15:0] len_q;

  logic        ovld_q, okind_q, olast_q;
  logic [87:0] odata_q;

  logic [31:0] rd_off;
  logic [15:0] rd_size;
  logic [SLOT_IW-1:0] ptr_inc;
  logic [32:0] rem;
  logic [15:0] fill_len;
  logic [33:0] noff_sum;
  logic [32:0] fill_noff;
  logic [31:0] ret_left;
  logic        out_free;
  logic        hit;
  logic        stat_more;
  status_e     st_code;
  logic [SLOT_IW-1:0] st_slot;

  always_comb begin
    rd_off   = off_q[ptr_q];
    rd_size  = size_q[ptr_q];
    ptr_inc  = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
    rem      = {1'b0, total_q} - noff_q;
    if (noff_q >= {1'b0, total_q}) fill_len = '0;
    else if (rem > {17'b0, seg_q}) fill_len = seg_q;
    else fill_len = rem[15:0];
    noff_sum  = {1'b0, noff_q} + {18'b0, seg_q};
    fill_noff = (noff_sum > OFF_CAP) ? OFF_CAP[32:0] : noff_sum[32:0];
    ret_left  = (left_q > {16'b0, rd_size}) ? left_q - {16'b0, rd_size} : '0;
    out_free  = !ovld_q || out_ready_i;
    hit       = (rd_size != '0) && (rd_off == start_q) && (rd_size == len_q);
    stat_more = fnd_v_q && !rdy_bits_q[fnd_q] &&
                (rdy_bits_q[head_q] || (fnd_q == head_q));
    if (act_q == ACT_BEGIN) begin
      st_code = ST_INIT;
      st_slot = '0;
    end else if (!fnd_v_q) begin
      st_code = ST_OUTSIDE;
      st_slot = '0;
    end else if (rdy_bits_q[fnd_q]) begin
      st_code = ST_DUP;
      st_slot = fnd_q;
    end else begin
      st_code = ST_ACCEPTED;
      st_slot = fnd_q;
    end
  end

  assign sts_o.is_begin  = (in_action_i == ACT_BEGIN);
  assign sts_o.cnt_end   = (cnt_q == LAST_IDX);
  assign sts_o.hit       = hit;
  assign sts_o.out_free  = out_free;
  assign sts_o.stat_more = (act_q == ACT_ARRIVAL) && stat_more;
  assign sts_o.ret_more  = (cnt_q != LAST_IDX) && rdy_bits_q[ptr_inc];

  assign out_valid_o = ovld_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;
  assign out_data_o  = odata_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      seg_q      <= SEG_SIZE_RST;
      rdy_bits_q <= '0;
      head_q     <= '0;
      noff_q     <= '0;
      left_q     <= '0;
      ovld_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_TOTAL_LEN: total_q <= cfg_data_i;
          REG_SEG_SIZE:  seg_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_ready_i && !cmd_i.stat && !cmd_i.ret) ovld_q <= 1'b0;
      if (cmd_i.take && (in_action_i == ACT_BEGIN)) noff_q <= '0;
      if (cmd_i.fill) begin
        rdy_bits_q[ptr_q] <= 1'b0;
        noff_q            <= fill_noff;
      end
      if (cmd_i.stat) begin
        ovld_q <= 1'b1;
        if (act_q == ACT_BEGIN) begin
          head_q <= '0;
          left_q <= total_q;
        end else if (stat_more || (fnd_v_q && !rdy_bits_q[fnd_q])) begin
          rdy_bits_q[fnd_q] <= 1'b1;
        end
      end
      if (cmd_i.ret) begin
        ovld_q            <= 1'b1;
        left_q            <= ret_left;
        rdy_bits_q[ptr_q] <= 1'b0;
        noff_q            <= fill_noff;
        head_q            <= ptr_inc;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q   <= in_action_i;
      start_q <= in_start_i;
      len_q   <= in_length_i;
      ptr_q   <= '0;
      cnt_q   <= '0;
      fnd_v_q <= 1'b0;
    end
    if (cmd_i.fill || cmd_i.ret) begin
      off_q[ptr_q]  <= noff_q[31:0];
      size_q[ptr_q] <= fill_len;
    end
    if (cmd_i.fill) begin
      ptr_q <= ptr_inc;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.scan) begin
      if (hit) begin
        fnd_q   <= ptr_q;
        fnd_v_q <= 1'b1;
      end
      ptr_q <= ptr_inc;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.stat) begin
      ptr_q   <= head_q;
      cnt_q   <= '0;
      okind_q <= KIND_STATUS;
      olast_q <= !sts_o.stat_more;
      odata_q <= {(act_q == ACT_BEGIN) ? total_q : left_q, 16'b0, 32'b0,
                  6'(st_slot), st_code};
    end
    if (cmd_i.ret) begin
      ptr_q   <= ptr_inc;
      cnt_q   <= cnt_q + 1'b1;
      okind_q <= KIND_RETIRE;
      olast_q <= !sts_o.ret_more;
      odata_q <= {ret_left, rd_size, rd_off, 6'(ptr_q), ST_ACCEPTED};
    end
  end

endmodule
`default_nettype wire

// File: sv/sliding_window_reassembly_core.sv
// top level of the selective-repeat receive window core
// depends on swr_pkg, swr_ctrl, swr_dp
//
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready        tdata seg_start, seg_length; tuser action
// m_axis   out  m_axis_tvalid/tready        tdata status..remaining; tuser kind; tlast
// cfg      in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// begin: all 32 slots filled from slot 0, then one status result
// arrival: slots compared from slot 0 until the first match (up to 32), one status
// result, then retired slots (up to 32); one slot ring entry a cycle unless stalled
// reset clears the ready bits and control at once; slot contents are written by begin
// a stalled result register holds the sequencer; config is always taken
`default_nettype none
module sliding_window_reassembly_core import swr_pkg::*; (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [47:0] s_axis_tdata,   // seg_start[31:0], seg_length[47:32]
  input  wire  logic        s_axis_tuser,   // action
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [87:0]       m_axis_tdata,   // status, slot, out_start, out_length, remaining
  output logic              m_axis_tuser,   // kind
  output logic              m_axis_tlast,
  input  wire  logic        cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  logic        cfg_index_i,
  input  wire  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  swr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_action_i (s_axis_tuser),
    .in_start_i  (s_axis_tdata[31:0]),
    .in_length_i (s_axis_tdata[47:32]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

// File: sv/swr_chk.sv
// port-level checker of the reassembly core, bound to the top level
// depends on sliding_window_reassembly_core_assert.svh
`default_nettype none
`include "sliding_window_reassembly_core_assert.svh"
module swr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `SWR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SWR_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SWR_ASSERT_IMPL(a_retire_status, m_axis_tvalid && m_axis_tuser, m_axis_tdata[1:0] == 2'd0)
  `SWR_ASSERT_IMPL(a_retire_not_last_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind sliding_window_reassembly_core swr_chk u_chk (.*);
`default_nettype wire

// File: bench/window_checker.sv
// checker for the reassembly core: watches the config, segment and result channels,
// keeps its own copy of the receive window and compares every result transfer
// depends on swr_pkg
`default_nettype none
module window_checker import swr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [87:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [5:0]  slot;
    logic [31:0] start;
    logic [15:0] length;
    logic [31:0] remaining;
    logic        last;
  } seg_result_t;

  seg_result_t due_results[$];

  logic [31:0] total_len_q = 32'd0;
  logic [15:0] seg_size_q  = SEG_SIZE_RST;
  logic [31:0] win_off   [WINDOW_SLOTS];
  logic [15:0] win_len   [WINDOW_SLOTS];
  logic        win_ready [WINDOW_SLOTS];
  int          head_q = 0;
  logic [32:0] next_off_q = '0;
  logic [31:0] left_q = '0;
  int          fails = 0;

  initial for (int k = 0; k < WINDOW_SLOTS; k++) win_ready[k] = 1'b0;

  assign fail_count_o = fails;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fails++;
  endtask

  task automatic refill_slot(int k);
    logic [32:0] len;
    logic [33:0] nxt;
    len = '0;
    if (next_off_q < {1'b0, total_len_q}) begin
      len = {1'b0, total_len_q} - next_off_q;
      if (len > {17'd0, seg_size_q}) len = {17'd0, seg_size_q};
    end
    win_off[k]   = next_off_q[31:0];
    win_len[k]   = len[15:0];
    win_ready[k] = 1'b0;
    nxt = {1'b0, next_off_q} + {18'd0, seg_size_q};
    if (nxt > 34'h1_0000_0000) nxt = 34'h1_0000_0000;
    next_off_q = nxt[32:0];
  endtask

  task automatic push_result(kind_e kd, status_e st, int sl, logic [31:0] s,
                             logic [15:0] l);
    seg_result_t r;
    r.kind = kd; r.status = st; r.slot = sl[5:0];
    r.start = s; r.length = l; r.remaining = left_q; r.last = 1'b0;
    due_results.push_back(r);
  endtask

  task automatic predict_window(action_e act, logic [31:0] start, logic [15:0] len);
    int found;
    int i;
    if (act == ACT_BEGIN) begin
      next_off_q = '0;
      for (int k = 0; k < WINDOW_SLOTS; k++) refill_slot(k);
      head_q = 0;
      left_q = total_len_q;
      push_result(KIND_STATUS, ST_INIT, 0, '0, '0);
    end else begin
      found = -1;
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        if (found < 0 && win_len[k] != 0 && win_off[k] == start && win_len[k] == len)
          found = k;
      end
      if (found < 0) begin
        push_result(KIND_STATUS, ST_OUTSIDE, 0, '0, '0);
      end else if (win_ready[found]) begin
        push_result(KIND_STATUS, ST_DUP, found, '0, '0);
      end else begin
        win_ready[found] = 1'b1;
        push_result(KIND_STATUS, ST_ACCEPTED, found, '0, '0);
        i = head_q;
        for (int c = 0; c < WINDOW_SLOTS && win_ready[i]; c++) begin
          left_q = (left_q > {16'd0, win_len[i]}) ? left_q - {16'd0, win_len[i]} : '0;
          push_result(KIND_RETIRE, ST_ACCEPTED, i, win_off[i], win_len[i]);
          refill_slot(i);
          i = (i + 1) % WINDOW_SLOTS;
        end
        head_q = i;
      end
    end
    due_results[due_results.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i) begin
    seg_result_t w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          report("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          w = due_results.pop_front();
          if (m_axis_tuser != w.kind)
            report("kind", 32'(m_axis_tuser), 32'(w.kind));
          if (m_axis_tdata[1:0] != w.status)
            report("status", 32'(m_axis_tdata[1:0]), 32'(w.status));
          if (m_axis_tdata[7:2] != w.slot)
            report("slot", 32'(m_axis_tdata[7:2]), 32'(w.slot));
          if (m_axis_tdata[39:8] != w.start) report("out_start", m_axis_tdata[39:8], w.start);
          if (m_axis_tdata[55:40] != w.length)
            report("out_length", 32'(m_axis_tdata[55:40]), 32'(w.length));
          if (m_axis_tdata[87:56] != w.remaining)
            report("remaining", m_axis_tdata[87:56], w.remaining);
          if (m_axis_tlast != w.last)
            report("last", 32'(m_axis_tlast), 32'(w.last));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_TOTAL_LEN) total_len_q = cfg_data_i;
        else seg_size_q = cfg_data_i[15:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_window(action_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[47:32]);
    end
    pending_o = due_results.size();
  end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// top of the reassembly core bench: clock, reset, segment and config stimulus,
// result back-pressure and verdict
// depends on swr_pkg, window_checker, sliding_window_reassembly_core
`default_nettype none
module tb_top import swr_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [87:0] m_data;
  logic        m_user;
  logic        m_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  bit          no_idle = 1'b0;
  int          res_seen = 0;

  sliding_window_reassembly_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  window_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_segment(action_e act, logic [31:0] start, logic [15:0] len);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= {len, start};
    do @(negedge clk); while (!s_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic good_arrival(logic [31:0] tot, logic [15:0] seg);
    longint unsigned nseg, jmax, j, st, len;
    nseg = (tot == 0) ? 1 : (longint'(tot) + seg - 1) / seg;
    jmax = ((nseg < 45) ? nseg : 45) + 2;
    j = longint'($urandom_range(0, int'(jmax) - 1));
    st = j * seg;
    len = (st < tot) ? ((tot - st < seg) ? tot - st : seg) : seg;
    send_segment(ACT_ARRIVAL, st[31:0], len[15:0]);
  endtask

  // receiver: random stall per result, one long hold-off to back the block up
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = draw_gap();
      if (res_seen == 150) n = 700;
      if (n > 0) begin
        m_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(negedge clk); while (!m_valid);
      @(posedge clk);
      res_seen++;
    end
  end

  initial begin
    logic [31:0] tots [8] = '{32'd0, 32'd40, 32'd100, 32'd196610, 32'hFFFF_FFFF,
                              32'd37, 32'd30000, 32'd12345};
    logic [15:0] segs [8] = '{16'd1, 16'd1, 16'd7, 16'd65535, 16'd65535,
                              16'd3, 16'd1000, 16'd400};
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window of 1000-byte segments with a short tail
    write_reg(REG_TOTAL_LEN, 32'd2500);
    send_segment(ACT_BEGIN, '0, '0);
    send_segment(ACT_ARRIVAL, 32'd0, 16'd1000);
    send_segment(ACT_ARRIVAL, 32'd0, 16'd1000);
    send_segment(ACT_ARRIVAL, 32'd2000, 16'd500);
    send_segment(ACT_ARRIVAL, 32'd2000, 16'd500);
    send_segment(ACT_ARRIVAL, 32'd1000, 16'd0);
    send_segment(ACT_ARRIVAL, 32'd1000, 16'd999);
    send_segment(ACT_ARRIVAL, 32'd3000, 16'd1000);
    send_segment(ACT_ARRIVAL, 32'hFFFF_FFFF, 16'hFFFF);
    send_segment(ACT_ARRIVAL, 32'd1000, 16'd1000);
    send_segment(ACT_ARRIVAL, 32'd0, 16'd0);
    send_segment(ACT_BEGIN, 32'hFFFF_FFFF, 16'hFFFF);
    send_segment(ACT_ARRIVAL, 32'd1000, 16'd1000);
    send_segment(ACT_ARRIVAL, 32'd0, 16'd1000);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_TOTAL_LEN, tots[p]);
      write_reg(REG_SEG_SIZE, 32'(segs[p]));
      no_idle = (p == 2 || p == 6);
      send_segment(ACT_BEGIN, $urandom(), 16'($urandom()));
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 19);
        if (r < 16) good_arrival(tots[p], segs[p]);
        else if (r < 19) send_segment(ACT_ARRIVAL, $urandom(), 16'($urandom()));
        else send_segment(ACT_BEGIN, $urandom(), 16'($urandom()));
      end
      drain();
    end
    no_idle = 1'b0;

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
